/* rtl/mcpf_pkg.sv */
`default_nettype none

package mcpf_pkg;

    localparam int unsigned PKT_LEN = 5;
    localparam int unsigned IDX_W   = $clog2(PKT_LEN);

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    localparam logic [7:0] FRONT_ADDRESS_RST    = 8'd128;
    localparam logic [7:0] BACK_ADDRESS_RST     = 8'd129;
    localparam logic [7:0] RIGHT_CMD_OFFSET_RST = 8'd4;
    localparam logic [7:0] SPEED_MASK_RST       = 8'h7F;

    typedef enum logic [1:0] {
        REG_FRONT_ADDRESS    = 2'd0,
        REG_BACK_ADDRESS     = 2'd1,
        REG_RIGHT_CMD_OFFSET = 2'd2,
        REG_SPEED_MASK       = 2'd3
    } mcpf_reg_idx_t;

    typedef struct packed {
        logic [7:0] front_address;
        logic [7:0] back_address;
        logic [7:0] right_cmd_offset;
        logic [7:0] speed_mask;
    } mcpf_cfg_t;

    // One command on its way through the pipeline
    typedef struct packed {
        logic        err;
        logic [7:0]  addr;
        logic [7:0]  cmd;
        logic [7:0]  spd;
        logic [15:0] crc;
    } mcpf_item_t;

    // CRC-16/XMODEM update by one byte, MSB first
    function automatic logic [15:0] mcpf_crc_byte(input logic [15:0] crc_in,
                                                  input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/mcpf_if.sv */
`default_nettype none

interface mcpf_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] position;
    logic [7:0] direction;
    logic [7:0] speed;

    modport source (output valid, position, direction, speed, input ready);
    modport sink   (input valid, position, direction, speed, output ready);
endinterface

interface mcpf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic       error;

    modport source (output valid, out_byte, last, error, input ready);
    modport sink   (input valid, out_byte, last, error, output ready);
endinterface

interface mcpf_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/mcpf_cfg_regs.sv */
`default_nettype none

module mcpf_cfg_regs
    import mcpf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire logic [1:0] wr_index,
    input  wire logic [7:0] wr_data,
    output mcpf_cfg_t       cfg
);

    mcpf_cfg_t cfg_reg;
    mcpf_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (mcpf_reg_idx_t'(wr_index))
                REG_FRONT_ADDRESS:    cfg_next.front_address    = wr_data;
                REG_BACK_ADDRESS:     cfg_next.back_address     = wr_data;
                REG_RIGHT_CMD_OFFSET: cfg_next.right_cmd_offset = wr_data;
                REG_SPEED_MASK:       cfg_next.speed_mask       = wr_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.front_address    <= FRONT_ADDRESS_RST;
            cfg_reg.back_address     <= BACK_ADDRESS_RST;
            cfg_reg.right_cmd_offset <= RIGHT_CMD_OFFSET_RST;
            cfg_reg.speed_mask       <= SPEED_MASK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/mcpf_decode.sv */
`default_nettype none

module mcpf_decode
    import mcpf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire mcpf_cfg_t  cfg,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] position,
    input  wire logic [7:0] direction,
    input  wire logic [7:0] speed,
    output logic            out_valid,
    input  wire logic       out_ready,
    output mcpf_item_t      out_item
);

    logic       valid_reg;
    mcpf_item_t item_reg;
    mcpf_item_t item_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        item_next.err  = |(speed & ~cfg.speed_mask);
        item_next.addr = position[1] ? cfg.back_address : cfg.front_address;
        // right-side wheels: wrap modulo 256
        item_next.cmd  = position[0] ? direction + cfg.right_cmd_offset : direction;
        item_next.spd  = speed;
        item_next.crc  = CRC_INIT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

/* rtl/mcpf_crc_stage.sv */
`default_nettype none

module mcpf_crc_stage
    import mcpf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire mcpf_item_t in_item,
    input  wire logic [7:0] fold_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output mcpf_item_t      out_item
);

    logic       valid_reg;
    mcpf_item_t item_reg;
    mcpf_item_t item_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        item_next     = in_item;
        item_next.crc = mcpf_crc_byte(in_item.crc, fold_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

/* rtl/mcpf_serializer.sv */
`default_nettype none

module mcpf_serializer
    import mcpf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire mcpf_item_t in_item,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last,
    output logic            out_error
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PKT_LEN - 1);

    logic             valid_reg;
    logic             valid_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    mcpf_item_t       item_reg;
    logic             load;
    logic             at_last;

    assign at_last  = item_reg.err || (idx_reg == LAST_IDX);
    // take the next packet once the final byte of this one goes out
    assign in_ready = !valid_reg || (out_ready && at_last);
    assign load     = in_ready && in_valid;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
            idx_next   = '0;
        end
        else if (out_ready)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= in_item;
    end

    always_comb
    begin
        case (idx_reg)
            IDX_W'(0): out_byte = item_reg.addr;
            IDX_W'(1): out_byte = item_reg.cmd;
            IDX_W'(2): out_byte = item_reg.spd;
            IDX_W'(3): out_byte = item_reg.crc[15:8];
            default:   out_byte = item_reg.crc[7:0];
        endcase
        if (item_reg.err)
            out_byte = 8'h00;
    end

    assign out_valid = valid_reg;
    assign out_last  = at_last;
    assign out_error = item_reg.err;

endmodule

`default_nettype wire

/* rtl/motor_command_packet_framer.sv */
`default_nettype none

// Motor command packet framer. Each command on cmd becomes five bytes on pkt:
// controller address, command, speed and the CRC-16/XMODEM of those three,
// high byte first, with last on the fifth; a speed outside speed_mask gives
// one byte of 0 with last and error set instead. Commands pass a four-stage
// pipeline (decode, then one CRC byte per stage) and then the serialiser
// register before the first byte of a packet appears. cmd is taken every
// cycle while the pipeline has room; the byte-wide output serialiser takes a
// new command only once the last byte of the current packet goes out (one
// per cycle for error results while pkt.ready is high). Configuration writes
// on cfg are always taken and must be made while no command is in flight.
module motor_command_packet_framer
    import mcpf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    mcpf_cmd_if.sink  cmd,
    mcpf_byte_if.source pkt,
    mcpf_cfg_if.sink  cfg
);

    mcpf_cfg_t  cfg_q;

    logic       dec_valid;
    logic       dec_ready;
    mcpf_item_t dec_item;
    logic       crc0_valid;
    logic       crc0_ready;
    mcpf_item_t crc0_item;
    logic       crc1_valid;
    logic       crc1_ready;
    mcpf_item_t crc1_item;
    logic       crc2_valid;
    logic       crc2_ready;
    mcpf_item_t crc2_item;

    assign cfg.ready = 1'b1;

    mcpf_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_q)
    );

    mcpf_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_q),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .position  (cmd.position),
        .direction (cmd.direction),
        .speed     (cmd.speed),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_item  (dec_item)
    );

    mcpf_crc_stage u_crc_addr (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_item   (dec_item),
        .fold_byte (dec_item.addr),
        .out_valid (crc0_valid),
        .out_ready (crc0_ready),
        .out_item  (crc0_item)
    );

    mcpf_crc_stage u_crc_cmd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (crc0_valid),
        .in_ready  (crc0_ready),
        .in_item   (crc0_item),
        .fold_byte (crc0_item.cmd),
        .out_valid (crc1_valid),
        .out_ready (crc1_ready),
        .out_item  (crc1_item)
    );

    mcpf_crc_stage u_crc_spd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (crc1_valid),
        .in_ready  (crc1_ready),
        .in_item   (crc1_item),
        .fold_byte (crc1_item.spd),
        .out_valid (crc2_valid),
        .out_ready (crc2_ready),
        .out_item  (crc2_item)
    );

    mcpf_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (crc2_valid),
        .in_ready  (crc2_ready),
        .in_item   (crc2_item),
        .out_valid (pkt.valid),
        .out_ready (pkt.ready),
        .out_byte  (pkt.out_byte),
        .out_last  (pkt.last),
        .out_error (pkt.error)
    );

    // an error result is always a single, empty byte
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        pkt.valid && pkt.error |-> pkt.last && (pkt.out_byte == 8'h00))
        else $error("error result not a lone zero byte");

    // a packet never breaks off in the middle
    a_pkt_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        pkt.valid && pkt.ready && !pkt.last |=> pkt.valid && !pkt.error)
        else $error("packet interrupted before its last byte");

    // the last stage only hands over while the output is free or finishing
    a_ser_handover: assert property (@(posedge clk) disable iff (!rst_n)
        crc2_valid && crc2_ready |-> !pkt.valid || (pkt.ready && pkt.last))
        else $error("serialiser loaded over an unfinished packet");

endmodule

`default_nettype wire
